>>> rtl/assert_macros.svh
// Assertion helpers for the bound checker rcpw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off while reset is held.
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Combinational-style check sampled on every rising clock edge outside reset.
`define CHK_ALWAYS(label, expr, msg) \
  `CHK_CLK(label, (1'b1 |-> (expr)), msg)

`endif

>>> rtl/rcpw_pkg.sv
`default_nettype none
package rcpw_pkg;

  localparam int CHANNEL_COUNT = 6;
  localparam int PIN_FIELDS    = 6;
  localparam int ACTIVE_CH     = (CHANNEL_COUNT < PIN_FIELDS) ? CHANNEL_COUNT : PIN_FIELDS;

  localparam int PULSE_W = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;

  localparam logic [CFG_W-1:0] MIN_PULSE_RST = 16'd1000;
  localparam logic [CFG_W-1:0] MAX_PULSE_RST = 16'd2000;

  // Register indexes on the configuration port.
  localparam logic REG_MIN_PULSE = 1'b0;
  localparam logic REG_MAX_PULSE = 1'b1;

  typedef struct packed {
    logic [PIN_FIELDS-1:0] pin_levels;
    logic [TIME_W-1:0]     time_us;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0]    width_ch0;
    logic [PULSE_W-1:0]    width_ch1;
    logic [PULSE_W-1:0]    width_ch2;
    logic [PULSE_W-1:0]    width_ch3;
    logic [PULSE_W-1:0]    width_ch4;
    logic [PULSE_W-1:0]    width_ch5;
    logic                  pulse_done;
    logic [PIN_FIELDS-1:0] updated_mask;
  } out_item_t;

  // Per-channel result of one sample, before it is committed.
  typedef struct packed {
    logic               done;
    logic               upd;
    logic [PULSE_W-1:0] width;
  } lane_stat_t;

endpackage
`default_nettype wire

>>> rtl/rc_pulse_width_capture.sv
// Channel | Handshake              | Word
// --------+------------------------+-------------------------------------
// in      | in_valid / in_ready    | in_data   (pin levels, timestamp)
// out     | out_valid / out_ready  | out_data  (six widths, done, mask)
// cfg     | cfg_we                 | cfg_idx, cfg_wdata (bound registers)
//
// One sample per clock while the output is not stalled: a word is held in the input register,
// then the per-channel edge logic writes the result register and commits state.
// out_valid rises when the word moves from the input register into the result register.
// Synchronous active-low reset clears edge state, widths and both valids,
// and loads the bounds with 1000 and 2000.
// A stalled output holds its word; the input register still drains into it
// in the cycle the output is taken, so in_ready is high then and no bubble forms.
`default_nettype none
module rc_pulse_width_capture (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rcpw_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rcpw_pkg::out_item_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_idx,
  input  wire logic [rcpw_pkg::CFG_W-1:0]  cfg_wdata
);
  import rcpw_pkg::*;

  logic                           s1_valid_r;
  in_item_t                       s1_item_r;
  logic                           out_valid_r;
  out_item_t                      out_item_r;
  out_item_t                      out_item_nxt;
  logic [CFG_W-1:0]               min_r;
  logic [CFG_W-1:0]               max_r;
  logic                           adv;
  lane_stat_t [ACTIVE_CH-1:0]     stat;
  logic [PIN_FIELDS-1:0][PULSE_W-1:0] widths;
  logic [PIN_FIELDS-1:0]          upd_mask;
  logic [PIN_FIELDS-1:0]          done_vec;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  for (genvar i = 0; i < PIN_FIELDS; i++) begin : g_ch
    if (i < ACTIVE_CH) begin : g_on
      rcpw_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .level     (s1_item_r.pin_levels[i]),
        .time_lo   (s1_item_r.time_us[PULSE_W-1:0]),
        .min_pulse (min_r),
        .max_pulse (max_r),
        .stat      (stat[i])
      );
      assign widths[i]   = stat[i].width;
      assign upd_mask[i] = stat[i].upd;
      assign done_vec[i] = stat[i].done;
    end else begin : g_off
      assign widths[i]   = '0;
      assign upd_mask[i] = 1'b0;
      assign done_vec[i] = 1'b0;
    end
  end

  always_comb begin
    out_item_nxt.width_ch0    = widths[0];
    out_item_nxt.width_ch1    = widths[1];
    out_item_nxt.width_ch2    = widths[2];
    out_item_nxt.width_ch3    = widths[3];
    out_item_nxt.width_ch4    = widths[4];
    out_item_nxt.width_ch5    = widths[5];
    out_item_nxt.pulse_done   = |done_vec;
    out_item_nxt.updated_mask = upd_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      min_r       <= MIN_PULSE_RST;
      max_r       <= MAX_PULSE_RST;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_MIN_PULSE: min_r <= cfg_wdata;
          REG_MAX_PULSE: max_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

>>> rtl/rcpw_lane.sv
`default_nettype none
module rcpw_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic                          level,
  input  wire logic [rcpw_pkg::PULSE_W-1:0]  time_lo,
  input  wire logic [rcpw_pkg::CFG_W-1:0]    min_pulse,
  input  wire logic [rcpw_pkg::CFG_W-1:0]    max_pulse,
  output rcpw_pkg::lane_stat_t               stat
);
  import rcpw_pkg::*;

  logic               prev_r;
  logic               high_r;
  logic               high_nxt;
  logic [PULSE_W-1:0] rise_r;
  logic [PULSE_W-1:0] width_r;
  logic [PULSE_W-1:0] width_nxt;
  logic               rise;
  logic               fall;
  logic               in_range;
  logic [PULSE_W-1:0] meas;

  // Only the low half of the timestamp survives the 16-bit truncation.
  assign rise     = level && !prev_r;
  assign fall     = !level && prev_r && high_r;
  assign meas     = time_lo - rise_r;
  assign in_range = (meas > min_pulse) && (meas < max_pulse);

  always_comb begin
    high_nxt  = high_r;
    width_nxt = width_r;
    if (rise) begin
      high_nxt = 1'b1;
    end else if (fall) begin
      high_nxt = 1'b0;
      if (in_range) begin
        width_nxt = meas;
      end
    end
  end

  assign stat.done  = fall;
  assign stat.upd   = fall && in_range;
  assign stat.width = width_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      high_r  <= 1'b0;
      width_r <= '0;
    end else if (adv) begin
      prev_r  <= level;
      high_r  <= high_nxt;
      width_r <= width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rise) begin
      rise_r <= time_lo;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rcpw_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rcpw_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire rcpw_pkg::out_item_t  out_data
);

  logic out_stall;
  logic mask_any;
  logic ch0_upd;

  assign out_stall = out_valid && !out_ready;
  assign mask_any  = |out_data.updated_mask;
  assign ch0_upd   = out_valid && out_data.updated_mask[0];

  `CHK_CLK(a_out_hold, (out_stall |=> out_valid && $stable(out_data)), "stalled word changed")
  `CHK_ALWAYS(a_no_bubble, (out_valid || in_ready), "input stalled with empty output")
  `CHK_ALWAYS(a_mask_done, (!out_valid || !mask_any || out_data.pulse_done), "mask without pulse")
  `CHK_ALWAYS(a_width_nz, (!ch0_upd || out_data.width_ch0 != '0), "zero width stored on ch0")

endmodule

bind rc_pulse_width_capture rcpw_checker u_rcpw_checker (.*);
`default_nettype wire

>>> tb/sv/rc_pulse_width_capture_checker.sv
`timescale 1ns / 100ps
module rc_pulse_width_capture_checker
  import rcpw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int FIELD_COUNT = 8;

  logic [CFG_W-1:0]      lo_bound;
  logic [CFG_W-1:0]      hi_bound;
  logic [PIN_FIELDS-1:0] prev_levels;
  logic                  in_pulse    [PIN_FIELDS];
  logic [TIME_W-1:0]     start_time  [PIN_FIELDS];
  logic [PULSE_W-1:0]    last_width  [PIN_FIELDS];
  out_item_t             width_words_due [$];
  out_item_t             due_word;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Edge detection and width capture for one sample; commits channel state.
  function automatic out_item_t capture_sample(in_item_t s);
    out_item_t             r;
    logic [PIN_FIELDS-1:0] changed;
    logic [PIN_FIELDS-1:0] upd;
    logic                  done;
    logic [TIME_W-1:0]     span;
    changed = s.pin_levels ^ prev_levels;
    upd     = '0;
    done    = 1'b0;
    for (int i = 0; i < ACTIVE_CH; i++) begin
      if (changed[i]) begin
        if (prev_levels[i]) begin
          if (in_pulse[i]) begin
            done        = 1'b1;
            in_pulse[i] = 1'b0;
            span        = s.time_us - start_time[i];
            if (span[PULSE_W-1:0] > lo_bound && span[PULSE_W-1:0] < hi_bound) begin
              last_width[i] = span[PULSE_W-1:0];
              upd[i]        = 1'b1;
            end
          end
        end else begin
          in_pulse[i]   = 1'b1;
          start_time[i] = s.time_us;
        end
      end
    end
    prev_levels    = s.pin_levels;
    r.width_ch0    = last_width[0];
    r.width_ch1    = last_width[1];
    r.width_ch2    = last_width[2];
    r.width_ch3    = last_width[3];
    r.width_ch4    = last_width[4];
    r.width_ch5    = last_width[5];
    r.pulse_done   = done;
    r.updated_mask = upd;
    return r;
  endfunction

  function automatic logic [PULSE_W-1:0] field_of(out_item_t o, int k);
    case (k)
      0:       return o.width_ch0;
      1:       return o.width_ch1;
      2:       return o.width_ch2;
      3:       return o.width_ch3;
      4:       return o.width_ch4;
      5:       return o.width_ch5;
      6:       return {{(PULSE_W-1){1'b0}}, o.pulse_done};
      default: return {{(PULSE_W-PIN_FIELDS){1'b0}}, o.updated_mask};
    endcase
  endfunction

  function automatic string field_name(int k);
    case (k)
      0:       return "width_ch0";
      1:       return "width_ch1";
      2:       return "width_ch2";
      3:       return "width_ch3";
      4:       return "width_ch4";
      5:       return "width_ch5";
      6:       return "pulse_done";
      default: return "updated_mask";
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lo_bound    = MIN_PULSE_RST;
      hi_bound    = MAX_PULSE_RST;
      prev_levels = '0;
      for (int i = 0; i < PIN_FIELDS; i++) begin
        in_pulse[i]   = 1'b0;
        start_time[i] = '0;
        last_width[i] = '0;
      end
      width_words_due.delete();
    end else begin
      // Compare first: a word accepted now was predicted at an earlier edge, not this one.
      if (out_valid && out_ready) begin
        if (width_words_due.size() == 0) begin
          $display("%0t: result word expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          due_word = width_words_due.pop_front();
          for (int k = 0; k < FIELD_COUNT; k++) begin
            if (field_of(out_data, k) !== field_of(due_word, k)) begin
              $display("%0t: %s expected %0h actual %0h", $time, field_name(k),
                       field_of(due_word, k), field_of(out_data, k));
              fail_count++;
            end
          end
        end
      end
      if (in_valid && in_ready)
        width_words_due.push_back(capture_sample(in_data));
      if (cfg_we) begin
        case (cfg_idx)
          REG_MIN_PULSE: lo_bound = cfg_wdata;
          REG_MAX_PULSE: hi_bound = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = width_words_due.size();
  end

endmodule

>>> tb/sv/rc_pulse_width_capture_tb.sv
`timescale 1ns / 100ps
module rc_pulse_width_capture_tb;
  import rcpw_pkg::*;

  localparam int PHASE_WORDS = 225;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = REG_MIN_PULSE;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending;

  int               in_calm = 0;
  int               out_calm = 0;
  int               out_hold = 0;
  logic             out_took = 1'b0;
  int               words_sent = 0;
  int               bound_lo = 1000;
  int               bound_hi = 2000;
  logic [TIME_W-1:0] now = '0;

  rc_pulse_width_capture u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rc_pulse_width_capture_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Per-word random wait, with occasional stretches of none.
  task automatic draw_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm   = $urandom_range(20, 60);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 12);
    end
  endtask

  always @(posedge clk) out_took <= out_valid && out_ready;

  always @(negedge clk) begin
    if (out_took)
      draw_wait(out_calm, out_hold);
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input logic [PIN_FIELDS-1:0] lvl, input logic [TIME_W-1:0] ts);
    int       gap;
    in_item_t w;
    draw_wait(in_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    w.pin_levels = lvl;
    w.time_us    = ts;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic set_bounds(input int lo, input int hi);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // let the pipeline settle before touching the bounds
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MIN_PULSE;
    cfg_wdata <= lo[CFG_W-1:0];
    @(negedge clk);
    cfg_idx   <= REG_MAX_PULSE;
    cfg_wdata <= hi[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    bound_lo = lo;
    bound_hi = hi;
  endtask

  function automatic logic [TIME_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return bound_lo;
      1:       return bound_lo + 1;
      2:       return bound_hi - 1;
      3:       return bound_hi;
      8:       return $urandom_range(0, 65535);
      9:       return 32'h1_0000 + $urandom_range(0, 65535);
      default: return $urandom_range(bound_lo, bound_hi);
    endcase
  endfunction

  // One receiver frame: rise on a set of channels, then fall in width order.
  task automatic run_frame();
    logic [PIN_FIELDS-1:0] lvl;
    logic [TIME_W-1:0]     base;
    logic [TIME_W-1:0]     step;
    logic [TIME_W-1:0]     offs [PIN_FIELDS];
    lvl = ($urandom_range(0, 3) == 0) ? PIN_FIELDS'($urandom_range(1, 63)) : '1;
    if ($urandom_range(0, 15) == 0)
      base = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else
      base = now + $urandom_range(50, 20000);
    for (int k = 0; k < PIN_FIELDS; k++)
      offs[k] = pick_width();
    send_sample(lvl, base);
    step = '0;
    while (lvl != '0) begin
      step = 32'hFFFF_FFFF;
      for (int k = 0; k < PIN_FIELDS; k++)
        if (lvl[k] && offs[k] <= step) step = offs[k];
      // idle sample inside the pulse, no edges
      if ($urandom_range(0, 5) == 0)
        send_sample(lvl, base + step / 2);
      for (int k = 0; k < PIN_FIELDS; k++)
        if (lvl[k] && offs[k] == step) lvl[k] = 1'b0;
      send_sample(lvl, base + step);
    end
    now = base + step;
  endtask

  task automatic run_phase(input int count);
    int start;
    start = words_sent;
    while (words_sent - start < count) begin
      case ($urandom_range(0, 7))
        0: send_sample(PIN_FIELDS'($urandom_range(0, 63)), $urandom);
        1: begin
          now = now + $urandom_range(0, 3000);
          send_sample(PIN_FIELDS'($urandom_range(0, 63)), now);
        end
        default: run_frame();
      endcase
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset bounds 1000 / 2000.
    send_sample(6'h00, 32'h0000_0000);
    send_sample(6'h3F, 32'hFFFF_FC00);
    send_sample(6'h00, 32'h0000_01DC);   // wrapped timestamp, width 1500
    send_sample(6'h15, 32'd100);
    send_sample(6'h2A, 32'd1100);        // width equal to the lower bound
    send_sample(6'h00, 32'd2101);        // one above the lower bound
    send_sample(6'h3F, 32'd5000);
    send_sample(6'h3E, 32'd6999);        // one below the upper bound
    send_sample(6'h3C, 32'd7000);        // equal to the upper bound
    send_sample(6'h00, 32'd72036);       // difference above 16 bits, truncated
    send_sample(6'h3F, 32'hFFFF_FFFF);
    send_sample(6'h00, 32'd1199);
    send_sample(6'h2A, 32'h5555_5555);
    send_sample(6'h15, 32'hAAAA_AAAA);
    send_sample(6'h00, 32'hAAAA_B000);
    send_sample(6'h00, 32'hAAAA_B100);
    now = 32'hAAAA_B100;

    run_phase(PHASE_WORDS);
    set_bounds(0, 65535);
    run_phase(PHASE_WORDS);
    set_bounds(65535, 0);                // empty window
    run_phase(PHASE_WORDS);
    set_bounds(1200, 1202);              // only 1201 passes
    run_phase(PHASE_WORDS);
    begin
      int lo;
      lo = $urandom_range(0, 3000);
      set_bounds(lo, lo + $urandom_range(2, 3000));
    end
    run_phase(PHASE_WORDS);
    set_bounds(1000, 2000);
    run_phase(PHASE_WORDS);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
